// File: design/bile_pkg.sv
// ----------------------------------------------------------------------------
// bile_pkg
// Shared types and codes for the bounded integer list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bile_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int ACTION_W     = 3;
  localparam int TAKE_W       = 7;

  // Input actions.
  localparam logic [ACTION_W-1:0] ACT_HEAD_INS  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TAIL_INS  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ORD_INS   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REM_HEAD  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REM_TAIL  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_TAKE      = 3'd5;

  // What a cell does with its value on the next edge.
  localparam logic [1:0] CELL_HOLD       = 2'd0;
  localparam logic [1:0] CELL_LOAD       = 2'd1;
  localparam logic [1:0] CELL_FROM_LEFT  = 2'd2;
  localparam logic [1:0] CELL_FROM_RIGHT = 2'd3;

  // Compare result of one cell against the key of an ordered insert.
  typedef struct packed {
    logic gt;
    logic ge;
  } cell_cmp_t;

endpackage

`default_nettype wire

// File: design/bile_cell.sv
// ----------------------------------------------------------------------------
// bile_cell
// One list position: holds an entry, shifts to or from its neighbors and
// compares its entry against the key of an ordered insert.
// ----------------------------------------------------------------------------
`default_nettype none

module bile_cell (
  input  wire logic                                  clk,
  input  wire logic [1:0]                            op,
  input  wire logic signed [bile_pkg::VALUE_W-1:0]   key,
  input  wire logic signed [bile_pkg::VALUE_W-1:0]   left_value,
  input  wire logic signed [bile_pkg::VALUE_W-1:0]   right_value,
  output logic signed [bile_pkg::VALUE_W-1:0]        value,
  output bile_pkg::cell_cmp_t                        cmp
);

  always_ff @(posedge clk) begin
    case (op)
      bile_pkg::CELL_LOAD:       value <= key;
      bile_pkg::CELL_FROM_LEFT:  value <= left_value;
      bile_pkg::CELL_FROM_RIGHT: value <= right_value;
      default:                   value <= value;
    endcase
  end

  assign cmp.gt = (value > key);
  assign cmp.ge = (value >= key);

endmodule

`default_nettype wire

// File: design/bounded_integer_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_integer_list_engine
// Deque with sorted insert held in a row of shifting cells.
// A non-take item gives one result; a take gives one result per entry taken
// (one failed result if none), on consecutive cycles, each after a one-step
// shift toward the head. Busy holds while an item executes or a take
// drains, so no new item is accepted before the last one has executed.
// Reset clears the entry count and control state; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_integer_list_engine #(
  parameter int CAPACITY = bile_pkg::CAPACITY_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [bile_pkg::ACTION_W-1:0]         action,
  input  wire logic signed [bile_pkg::VALUE_W-1:0]   item_value,
  input  wire logic [bile_pkg::TAKE_W-1:0]           take_count,
  output logic                                       done,
  output logic                                       ok,
  output logic signed [bile_pkg::VALUE_W-1:0]        taken_value,
  output logic                                       last
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_TAKE = 2'd2;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic [CW-1:0]                       cnt;
  logic [CW-1:0]                       cnt_next;
  logic [CW-1:0]                       rem;
  logic [bile_pkg::ACTION_W-1:0]       act;
  logic signed [bile_pkg::VALUE_W-1:0] val;
  logic [CAPACITY-1:0]                 flags;

  logic signed [bile_pkg::VALUE_W-1:0] cell_val [CAPACITY];
  bile_pkg::cell_cmp_t                 cell_cmp [CAPACITY];
  logic [CAPACITY-1:0]                 flags_now;
  logic [CAPACITY-1:0]                 tail_mask;
  logic [CAPACITY-1:0]                 ins_mask;
  logic                                do_ins;
  logic                                do_shl;
  logic                                full;
  logic                                res_fire;
  logic                                res_ok;
  logic                                accept;
  logic [CW-1:0]                       rem_now;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign full   = (cnt == CW'(CAPACITY));

  // A cell flags itself when it is valid and the key belongs at or before it.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        flags_now[i] = (CW'(i) < cnt) && cell_cmp[i].gt;
      end else begin
        flags_now[i] = (CW'(i) < cnt) && cell_cmp[i].ge;
      end
      tail_mask[i] = (CW'(i) >= cnt);
    end
  end

  assign rem_now = (take_count > bile_pkg::TAKE_W'(cnt)) ? cnt : CW'(take_count);

  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= action;
      val   <= item_value;
      flags <= flags_now;
    end
  end

  // Execute step: pick the insert mask (all positions at or after the insert
  // point) or a shift toward the head, and the result of the item.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ins_mask   = '0;
    do_ins     = 1'b0;
    do_shl     = 1'b0;
    res_fire   = 1'b0;
    res_ok     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        res_fire   = 1'b1;
        case (act)
          bile_pkg::ACT_HEAD_INS: begin
            ins_mask = '1;
            do_ins   = !full;
          end
          bile_pkg::ACT_TAIL_INS: begin
            ins_mask = tail_mask;
            do_ins   = !full;
          end
          bile_pkg::ACT_ORD_INS: begin
            // x | -x sets every bit from the lowest flagged cell upward.
            ins_mask = flags | (~flags + CAPACITY'(1)) | tail_mask;
            do_ins   = !full;
          end
          bile_pkg::ACT_REM_HEAD: begin
            do_shl = (cnt != '0);
            res_ok = (cnt != '0);
            if (cnt != '0) begin
              cnt_next = cnt - CW'(1);
            end
          end
          bile_pkg::ACT_REM_TAIL: begin
            res_ok = (cnt != '0);
            if (cnt != '0) begin
              cnt_next = cnt - CW'(1);
            end
          end
          bile_pkg::ACT_TAKE: begin
            if (rem != '0) begin
              state_next = ST_TAKE;
              res_fire   = 1'b0;
            end
          end
          default: begin
            res_ok = 1'b0;
          end
        endcase
        if (do_ins) begin
          res_ok   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      ST_TAKE: begin
        do_shl   = 1'b1;
        cnt_next = cnt - CW'(1);
        if (rem == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= res_fire || (state == ST_TAKE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem <= rem_now;
    end else if (state == ST_TAKE) begin
      rem <= rem - CW'(1);
    end
    if (state == ST_TAKE) begin
      ok          <= 1'b1;
      taken_value <= cell_val[0];
      last        <= (rem == CW'(1));
    end else begin
      ok          <= res_ok;
      taken_value <= '0;
      last        <= 1'b1;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [1:0]                          op;
    logic                                prev_in;
    logic signed [bile_pkg::VALUE_W-1:0] left_v;
    logic signed [bile_pkg::VALUE_W-1:0] right_v;

    if (g == 0) begin : g_head
      assign prev_in = 1'b0;
      assign left_v  = val;
    end else begin : g_body
      assign prev_in = ins_mask[g-1];
      assign left_v  = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_v = cell_val[g];
    end else begin : g_mid
      assign right_v = cell_val[g+1];
    end

    always_comb begin
      if (do_shl) begin
        op = bile_pkg::CELL_FROM_RIGHT;
      end else if (do_ins && ins_mask[g]) begin
        op = prev_in ? bile_pkg::CELL_FROM_LEFT : bile_pkg::CELL_LOAD;
      end else begin
        op = bile_pkg::CELL_HOLD;
      end
    end

    // During an accept the key is the arriving value so the compare lines
    // up with the flags register; during execution it is the stored value.
    bile_cell u_cell (
      .clk         (clk),
      .op          (op),
      .key         ((state == ST_IDLE) ? item_value : val),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[g]),
      .cmp         (cell_cmp[g])
    );
  end

endmodule

`default_nettype wire

// File: tb/bile_checker.sv
// ----------------------------------------------------------------------------
// bile_checker
// Watches the item and result ports of the bounded integer list engine. It
// keeps its own copy of the list, works out the results each accepted item
// must give, and compares every result strobe against the oldest one due.
// ----------------------------------------------------------------------------
module bile_checker #(
  parameter int CAPACITY = bile_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic                                 busy,
  input  wire logic [bile_pkg::ACTION_W-1:0]        action,
  input  wire logic signed [bile_pkg::VALUE_W-1:0]  item_value,
  input  wire logic [bile_pkg::TAKE_W-1:0]          take_count,
  input  wire logic                                 done,
  input  wire logic                                 ok,
  input  wire logic signed [bile_pkg::VALUE_W-1:0]  taken_value,
  input  wire logic                                 last,
  output int                                        fail_count,
  output int                                        open_count
);
  import bile_pkg::*;

  typedef struct packed {
    logic                       ok;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } list_result_t;

  logic signed [VALUE_W-1:0] held[$];
  list_result_t              results_due[$];

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  // Ordered insert: the head slot only when the head is strictly greater,
  // otherwise the first slot from 1 on whose entry is not below the value.
  function automatic int sorted_slot(input logic signed [VALUE_W-1:0] v);
    int p;
    if (held.size() == 0 || held[0] > v) return 0;
    p = 1;
    while (p < held.size() && v > held[p]) p++;
    return p;
  endfunction

  task automatic apply_list_action(input logic [ACTION_W-1:0] act,
                                   input logic signed [VALUE_W-1:0] v,
                                   input logic [TAKE_W-1:0] n);
    list_result_t r;
    int           count;
    r.ok    = 1'b0;
    r.value = '0;
    r.last  = 1'b1;
    case (act)
      ACT_HEAD_INS: if (held.size() < CAPACITY) begin
        held.push_front(v);
        r.ok = 1'b1;
      end
      ACT_TAIL_INS: if (held.size() < CAPACITY) begin
        held.push_back(v);
        r.ok = 1'b1;
      end
      ACT_ORD_INS: if (held.size() < CAPACITY) begin
        held.insert(sorted_slot(v), v);
        r.ok = 1'b1;
      end
      ACT_REM_HEAD: if (held.size() > 0) begin
        void'(held.pop_front());
        r.ok = 1'b1;
      end
      ACT_REM_TAIL: if (held.size() > 0) begin
        void'(held.pop_back());
        r.ok = 1'b1;
      end
      ACT_TAKE: if (n != 0 && held.size() > 0) begin
        count = (int'(n) > held.size()) ? held.size() : int'(n);
        for (int i = 0; i < count; i++) begin
          r.ok    = 1'b1;
          r.value = held.pop_front();
          r.last  = (i == count - 1);
          results_due.push_back(r);
        end
        return;
      end
      default: ;
    endcase
    results_due.push_back(r);
  endtask

  task automatic note_failure(input bit orphan, input list_result_t want,
                              input list_result_t got);
    if (fail_count < 10) begin
      if (orphan)
        $display("%0t: result with no item waiting: ok=%0b value=%0d last=%0b",
                 $realtime, got.ok, got.value, got.last);
      else
        $display("%0t: mismatch: expected ok=%0b value=%0d last=%0b, got ok=%0b value=%0d last=%0b",
                 $realtime, want.ok, want.value, want.last, got.ok, got.value, got.last);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst) begin
      held.delete();
      results_due.delete();
    end else begin
      if (start && !busy) apply_list_action(action, item_value, take_count);
      if (done) begin
        got.ok    = ok;
        got.value = taken_value;
        got.last  = last;
        if (results_due.size() == 0) begin
          note_failure(1'b1, got, got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) note_failure(1'b0, want, got);
        end
      end
    end
    open_count <= results_due.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bounded integer list engine: a directed opening over the
// empty and full list, extreme values and odd take counts, then random
// items in alternating fill and drain stretches with random idle gaps.
// ----------------------------------------------------------------------------
module tb;
  import bile_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_B = 3'd7;
  localparam int                  ITEM_TARGET  = 500;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      start      = 1'b0;
  logic [ACTION_W-1:0]       action     = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic [TAKE_W-1:0]         take_count = '0;
  logic                      busy;
  logic                      done;
  logic                      ok;
  logic signed [VALUE_W-1:0] taken_value;
  logic                      last;
  int                        fail_count;
  int                        open_count;
  bit                        idle_on = 1'b1;

  always #5 clk = ~clk;

  bounded_integer_list_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .item_value(item_value), .take_count(take_count), .done(done), .ok(ok),
    .taken_value(taken_value), .last(last)
  );

  bile_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .item_value(item_value), .take_count(take_count), .done(done), .ok(ok),
    .taken_value(taken_value), .last(last), .fail_count(fail_count),
    .open_count(open_count)
  );

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Small values give plenty of duplicates for the ordered insert.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom;
    if (r < 80) return $urandom_range(8) - 4;
    if (r < 90) return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return ($urandom_range(1)) ? 32'sh7FFF_FFFF - $urandom_range(3)
                               : 32'sh8000_0000 + $urandom_range(3);
  endfunction

  function automatic logic [TAKE_W-1:0] pick_take_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return TAKE_W'($urandom_range(8, 1));
    if (r < 85) return TAKE_W'($urandom_range(64, 9));
    if (r < 93) return TAKE_W'($urandom_range(127, 65));
    return '0;
  endfunction

  // Leaves start high after acceptance so a back-to-back item needs no
  // second assignment in the same step.
  task automatic issue_item(input logic [ACTION_W-1:0] act,
                            input logic signed [VALUE_W-1:0] v,
                            input logic [TAKE_W-1:0] n);
    int gap;
    gap = 0;
    if (idle_on) while ($urandom_range(99) < 19) gap++;
    if (gap > 0) begin
      start      <= 1'b0;
      action     <= ACTION_W'($urandom);
      item_value <= $urandom;
      take_count <= TAKE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    item_value <= v;
    take_count <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic signed [VALUE_W-1:0] fill_vals[16];
    logic [ACTION_W-1:0]       act;
    int                        valid_items;
    int                        r;
    bit                        filling;

    fill_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 0, 32'sh7FFF_FFFE,
                  32'sh8000_0001, 5, 5, -5, 100, -100, 0, 3, 3};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: removals and take fail, an unused action gives a failed result.
    issue_item(ACT_REM_HEAD, 0, 1);
    issue_item(ACT_REM_TAIL, 0, 1);
    issue_item(ACT_TAKE, 0, 1);
    issue_item(ACT_UNUSED_A, 32'sh1234_5678, 3);

    // Fill to capacity with all three inserts, with a zero-count take and
    // the other unused action along the way.
    for (int i = 0; i < 16; i++) begin
      case (i % 3)
        0:       act = ACT_HEAD_INS;
        1:       act = ACT_TAIL_INS;
        default: act = ACT_ORD_INS;
      endcase
      issue_item(act, fill_vals[i], 0);
      if (i == 6) issue_item(ACT_TAKE, 0, 0);
      if (i == 11) issue_item(ACT_UNUSED_B, -1, 127);
    end

    // Full list rejects every insert; then an oversized take drains it.
    issue_item(ACT_HEAD_INS, 42, 0);
    issue_item(ACT_TAIL_INS, -42, 0);
    issue_item(ACT_ORD_INS, 0, 0);
    issue_item(ACT_TAKE, 0, 127);

    valid_items = 0;
    while (valid_items < ITEM_TARGET) begin
      idle_on = !(valid_items >= 200 && valid_items < 320);
      filling = ((valid_items / 24) % 2) == 0;
      r = $urandom_range(99);
      if (r < 3) begin
        act = ACT_UNUSED_A;
      end else if (r < 6) begin
        act = ACT_UNUSED_B;
      end else if (r < (filling ? 70 : 35)) begin
        case ($urandom_range(3))
          0:       act = ACT_HEAD_INS;
          1:       act = ACT_TAIL_INS;
          default: act = ACT_ORD_INS;
        endcase
      end else if (r < (filling ? 80 : 55)) begin
        act = ACT_REM_HEAD;
      end else if (r < (filling ? 88 : 70)) begin
        act = ACT_REM_TAIL;
      end else begin
        act = ACT_TAKE;
      end
      issue_item(act, pick_value(), pick_take_count());
      if (act <= ACT_TAKE) valid_items++;
    end

    start <= 1'b0;
    @(posedge clk);
    wait (open_count == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
